### design/grid_toggle_rectangle_count_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the grid toggle rectangle count block
// Shared property wrappers with the block clock and reset.
// ----------------------------------------------------------------------------
`ifndef GRID_TOGGLE_RECTANGLE_COUNT_MACROS_SVH
`define GRID_TOGGLE_RECTANGLE_COUNT_MACROS_SVH

// Check a property while out of reset.
`define GTRC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every edge, reset included.
`define GTRC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### design/gtrc_pkg.sv
// ----------------------------------------------------------------------------
// gtrc_pkg
// Types and constants shared by the grid toggle rectangle count modules.
// ----------------------------------------------------------------------------
`default_nettype none

package gtrc_pkg;

    localparam int COORD_W = 8;
    localparam int COUNT_W = 17;
    localparam int SIDE_W  = 9;
    localparam int Q_DEPTH = 2;

    localparam logic [COUNT_W-1:0] MAX_COUNT = 17'd65536;

    localparam logic CMD_TOGGLE = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef enum logic [1:0] {
        K_TOGGLE,
        K_QUERY,
        K_BAD
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row_end;
        logic [COORD_W-1:0] col_end;
    } t_op;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CELL_RD,
        S_CELL_UPD,
        S_T_RD,
        S_T_WR,
        S_Q_LOAD,
        S_Q_RUN,
        S_Q_DRAIN,
        S_DONE
    } t_bstate;

endpackage

`default_nettype wire

### design/gtrc_ram.sv
// ----------------------------------------------------------------------------
// gtrc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gtrc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### design/gtrc_queue.sv
// ----------------------------------------------------------------------------
// gtrc_queue
// Short FIFO of classified commands between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module gtrc_queue import gtrc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_op  i_op,
    output logic      o_ready,
    output logic      o_valid,
    output t_op       o_op,
    input  wire logic i_pop
);

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(Q_DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(Q_DEPTH);

    t_op           r_mem [Q_DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_ready = (r_cnt != FULL);
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_mem[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == LAST) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == LAST) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_op;
        end
    end

endmodule

`default_nettype wire

### design/gtrc_front.sv
// ----------------------------------------------------------------------------
// gtrc_front
// Holds the side register, accepts input beats and classifies them.
// ----------------------------------------------------------------------------
`default_nettype none

module gtrc_front import gtrc_pkg::*; #(
    parameter int MAX_SIDE = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [SIDE_W-1:0]  i_cfg_wdata,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_command,
    input  wire logic [COORD_W-1:0] i_row,
    input  wire logic [COORD_W-1:0] i_col,
    input  wire logic [COORD_W-1:0] i_row_end,
    input  wire logic [COORD_W-1:0] i_col_end,
    input  wire t_back_stat         i_back_stat,
    input  wire logic               i_q_ready,
    output logic                    o_push,
    output t_op                     o_op
);

    localparam int SW = ($clog2(MAX_SIDE + 1) > SIDE_W) ? $clog2(MAX_SIDE + 1) : SIDE_W;
    localparam logic [SW-1:0] SIDE_MAX   = SW'(MAX_SIDE);
    localparam logic [SW-1:0] SIDE_RESET = (MAX_SIDE < 256) ? SW'(MAX_SIDE) : SW'(256);

    logic [SW-1:0] r_side, n_side;
    logic [SW-1:0] wdata_w;
    logic          drop;
    logic          bad;

    assign wdata_w = SW'(i_cfg_wdata);

    // Clamp the written side into one .. MAX_SIDE.
    always_comb begin
        n_side = r_side;
        if (i_cfg_we) begin
            if (wdata_w == '0) begin
                n_side = SW'(1);
            end else if (wdata_w > SIDE_MAX) begin
                n_side = SIDE_MAX;
            end else begin
                n_side = wdata_w;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= SIDE_RESET;
        end else begin
            r_side <= n_side;
        end
    end

    always_comb begin
        drop = (i_command == CMD_TOGGLE)
            && ((SW'(i_row) >= r_side) || (SW'(i_col) >= r_side));
        bad  = (i_row > i_row_end) || (i_col > i_col_end)
            || (SW'(i_row_end) >= r_side) || (SW'(i_col_end) >= r_side);
        o_op.row     = i_row;
        o_op.col     = i_col;
        o_op.row_end = i_row_end;
        o_op.col_end = i_col_end;
        if (i_command == CMD_TOGGLE) begin
            o_op.kind = K_TOGGLE;
        end else if (bad) begin
            o_op.kind = K_BAD;
        end else begin
            o_op.kind = K_QUERY;
        end
    end

    assign o_in_ready = i_q_ready && !i_back_stat.clearing;
    // Out-of-side toggles are taken and dropped here.
    assign o_push     = i_in_valid && o_in_ready && !drop;

endmodule

`default_nettype wire

### design/gtrc_back.sv
// ----------------------------------------------------------------------------
// gtrc_back
// Sequencer that clears the stores, walks tree updates and prefix sums.
// ----------------------------------------------------------------------------
`default_nettype none

module gtrc_back import gtrc_pkg::*; #(
    parameter int MAX_SIDE = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_valid,
    input  wire t_op                i_q_op,
    output logic                    o_q_pop,
    output t_back_stat              o_stat,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic      [COUNT_W-1:0] o_count,
    output logic                    o_status
);

    localparam int IW    = $clog2(MAX_SIDE);
    localparam int CELLS = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int NW    = COORD_W + 1;
    localparam logic [IW:0]   SIDE_LIM = (IW + 1)'(MAX_SIDE);
    localparam logic [AW-1:0] LAST_ADR = AW'(CELLS - 1);

    function automatic logic [AW-1:0] f_addr(logic [IW-1:0] r, logic [IW-1:0] c);
        return AW'(r) * AW'(MAX_SIDE) + AW'(c);
    endfunction

    t_bstate              r_state, n_state;
    t_op                  r_op, n_op;
    logic [IW:0]          r_i, n_i;
    logic [IW:0]          r_j, n_j;
    logic                 r_dec, n_dec;
    logic [NW-1:0]        r_nr, n_nr;
    logic [NW-1:0]        r_nc, n_nc;
    logic [NW-1:0]        r_cols0, n_cols0;
    logic [1:0]           r_corner, n_corner;
    logic                 r_sub, n_sub;
    logic                 r_pend, n_pend;
    logic                 r_pend_sub, n_pend_sub;
    logic [COUNT_W-1:0]   r_acc, n_acc;
    logic [AW-1:0]        r_clr, n_clr;
    logic                 r_out_valid, n_out_valid;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic                 r_status, n_status;

    logic [IW-1:0]        idx_r;
    logic [IW-1:0]        idx_c;
    logic [AW-1:0]        addr;
    logic                 tree_we;
    logic [COUNT_W-1:0]   tree_wd;
    logic [COUNT_W-1:0]   tree_rd;
    logic                 cell_we;
    logic                 cell_wd;
    logic                 cell_rd;
    logic [AW-1:0]        wr_addr;
    logic [NW-1:0]        c_rows;
    logic [NW-1:0]        c_cols;
    logic                 c_sub;
    logic [NW-1:0]        nc_step;
    logic [NW-1:0]        nr_step;
    logic [IW:0]          j_step;
    logic [IW:0]          i_step;
    logic                 query_walk;

    // One multiplier serves every address but the clearing one: cell, tree update and prefix read.
    assign query_walk = (r_state == S_Q_RUN);
    assign idx_r      = query_walk ? IW'(r_nr - 1'b1) : IW'(r_i);
    assign idx_c      = query_walk ? IW'(r_nc - 1'b1) : IW'(r_j);
    assign addr       = f_addr(idx_r, idx_c);
    assign wr_addr    = (r_state == S_CLEAR) ? r_clr : addr;

    assign nc_step = r_nc & (r_nc - 1'b1);
    assign nr_step = r_nr & (r_nr - 1'b1);
    assign j_step  = r_j | (r_j + 1'b1);
    assign i_step  = r_i | (r_i + 1'b1);

    // Corners of the inclusion-exclusion, with their sign.
    always_comb begin
        case (r_corner)
            2'd0: begin
                c_rows = NW'(r_op.row_end) + 1'b1;
                c_cols = NW'(r_op.col_end) + 1'b1;
                c_sub  = 1'b0;
            end
            2'd1: begin
                c_rows = NW'(r_op.row);
                c_cols = NW'(r_op.col);
                c_sub  = 1'b0;
            end
            2'd2: begin
                c_rows = NW'(r_op.row);
                c_cols = NW'(r_op.col_end) + 1'b1;
                c_sub  = 1'b1;
            end
            default: begin
                c_rows = NW'(r_op.row_end) + 1'b1;
                c_cols = NW'(r_op.col);
                c_sub  = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_i         = r_i;
        n_j         = r_j;
        n_dec       = r_dec;
        n_nr        = r_nr;
        n_nc        = r_nc;
        n_cols0     = r_cols0;
        n_corner    = r_corner;
        n_sub       = r_sub;
        n_pend      = 1'b0;
        n_pend_sub  = r_pend_sub;
        n_acc       = r_acc;
        n_clr       = r_clr;
        n_out_valid = r_out_valid && !i_out_ready;
        n_count     = r_count;
        n_status    = r_status;
        o_q_pop     = 1'b0;
        tree_we     = 1'b0;
        tree_wd     = '0;
        cell_we     = 1'b0;
        cell_wd     = 1'b0;

        // Fold in the tree entry read in the previous cycle.
        if (r_pend) begin
            n_acc = r_pend_sub ? r_acc - tree_rd : r_acc + tree_rd;
        end

        case (r_state)
            S_CLEAR: begin
                tree_we = 1'b1;
                cell_we = 1'b1;
                n_clr   = r_clr + 1'b1;
                if (r_clr == LAST_ADR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop  = 1'b1;
                    n_op     = i_q_op;
                    n_i      = (IW + 1)'(i_q_op.row);
                    n_j      = (IW + 1)'(i_q_op.col);
                    n_acc    = '0;
                    n_corner = 2'd0;
                    case (i_q_op.kind)
                        K_TOGGLE: n_state = S_CELL_RD;
                        K_QUERY:  n_state = S_Q_LOAD;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_CELL_RD: begin
                n_state = S_CELL_UPD;
            end
            S_CELL_UPD: begin
                cell_we = 1'b1;
                cell_wd = !cell_rd;
                n_dec   = cell_rd;
                n_state = S_T_RD;
            end
            S_T_RD: begin
                n_state = S_T_WR;
            end
            S_T_WR: begin
                tree_we = 1'b1;
                tree_wd = r_dec ? tree_rd - 1'b1 : tree_rd + 1'b1;
                if (j_step < SIDE_LIM) begin
                    n_j     = j_step;
                    n_state = S_T_RD;
                end else if (i_step < SIDE_LIM) begin
                    n_i     = i_step;
                    n_j     = (IW + 1)'(r_op.col);
                    n_state = S_T_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_Q_LOAD: begin
                n_nr    = c_rows;
                n_nc    = c_cols;
                n_cols0 = c_cols;
                n_sub   = c_sub;
                n_state = S_Q_RUN;
            end
            S_Q_RUN: begin
                if ((r_nr == '0) || (r_nc == '0)) begin
                    n_nr = '0;
                end else begin
                    n_pend     = 1'b1;
                    n_pend_sub = r_sub;
                    if (nc_step != '0) begin
                        n_nc = nc_step;
                    end else begin
                        n_nc = r_cols0;
                        n_nr = nr_step;
                    end
                end
                if (n_nr == '0) begin
                    n_corner = r_corner + 1'b1;
                    n_state  = (r_corner == 2'd3) ? S_Q_DRAIN : S_Q_LOAD;
                end
            end
            S_Q_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_count     = r_acc;
                    n_status    = (r_op.kind == K_BAD) ? STATUS_BAD : STATUS_OK;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_i        <= n_i;
        r_j        <= n_j;
        r_dec      <= n_dec;
        r_nr       <= n_nr;
        r_nc       <= n_nc;
        r_cols0    <= n_cols0;
        r_corner   <= n_corner;
        r_sub      <= n_sub;
        r_pend_sub <= n_pend_sub;
        r_acc      <= n_acc;
        r_count    <= n_count;
        r_status   <= n_status;
    end

    gtrc_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (CELLS)
    ) u_tree_ram (
        .i_clk     (i_clk),
        .i_we      (tree_we),
        .i_wr_addr (wr_addr),
        .i_wr_data (tree_wd),
        .i_rd_addr (addr),
        .o_rd_data (tree_rd)
    );

    gtrc_ram #(
        .WIDTH (1),
        .DEPTH (CELLS)
    ) u_cell_ram (
        .i_clk     (i_clk),
        .i_we      (cell_we),
        .i_wr_addr (wr_addr),
        .i_wr_data (cell_wd),
        .i_rd_addr (addr),
        .o_rd_data (cell_rd)
    );

    assign o_stat.clearing = (r_state == S_CLEAR);
    assign o_out_valid     = r_out_valid;
    assign o_count         = r_count;
    assign o_status        = r_status;

endmodule

`default_nettype wire

### design/grid_toggle_rectangle_count.sv
// ----------------------------------------------------------------------------
// grid_toggle_rectangle_count
// Toggleable square bit grid with rectangle population counts.
// ----------------------------------------------------------------------------
// The block keeps a MAX_SIDE by MAX_SIDE bit grid and a two-dimensional
// Fenwick tree of set-cell counts in two RAMs. After reset it runs a clearing
// pass over all MAX_SIDE*MAX_SIDE cells (65536 at the default) with o_in_ready low;
// configuration writes are still taken then. A toggle beat (command 0) flips
// one cell and adds +1 or -1 along the tree update path; it yields no result,
// and a toggle outside side_in_use is dropped. A query beat (command 1) yields
// one result beat with the set-cell count of the inclusive rectangle
// [row..row_end] x [col..col_end]; reversed corners or a corner at or beyond
// side_in_use give count 0 and status 1. Beats are classified on entry, held
// in a two-entry queue and then carried out one at a time by a sequencer
// around the tree RAM, whose single read port sets the rate. A toggle reads
// and rewrites its cell, then reads and writes each tree entry on its update
// path (up to 9 by 9 entries at the default size); a query loads each of the
// four corners and reads its tree entries, an empty corner still walked once
// (up to 8 by 8 entries per corner), then drains; a bad query goes straight
// to its result. A result held off by i_out_ready adds its stall. Results sit
// in an output register, so the next beat is taken while one waits.
// Write side_in_use only while the block is idle; 0 is taken as 1 and a value
// above MAX_SIDE as MAX_SIDE.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_toggle_rectangle_count import gtrc_pkg::*; #(
    parameter int MAX_SIDE = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration
    input  wire logic               i_cfg_we,
    input  wire logic [SIDE_W-1:0]  i_cfg_wdata,
    // command channel
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_command,
    input  wire logic [COORD_W-1:0] i_row,
    input  wire logic [COORD_W-1:0] i_col,
    input  wire logic [COORD_W-1:0] i_row_end,
    input  wire logic [COORD_W-1:0] i_col_end,
    // result channel
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic      [COUNT_W-1:0] o_count,
    output logic                    o_status
);

    t_back_stat back_stat;
    t_op        push_op;
    t_op        q_op;
    logic       push;
    logic       q_ready;
    logic       q_valid;
    logic       q_pop;

    // Front: side register, classification of each command beat.
    gtrc_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_row_end   (i_row_end),
        .i_col_end   (i_col_end),
        .i_back_stat (back_stat),
        .i_q_ready   (q_ready),
        .o_push      (push),
        .o_op        (push_op)
    );

    // Queue: decouples intake from the long tree walks.
    gtrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_op    (q_op),
        .i_pop   (q_pop)
    );

    // Back: clearing pass, toggle updates, four-corner prefix sums, result.
    gtrc_back #(
        .MAX_SIDE (MAX_SIDE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_op      (q_op),
        .o_q_pop     (q_pop),
        .o_stat      (back_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_count     (o_count),
        .o_status    (o_status)
    );

endmodule

`default_nettype wire

### design/gtrc_checker.sv
// ----------------------------------------------------------------------------
// gtrc_checker
// Port-level assertions for the grid toggle rectangle count block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "grid_toggle_rectangle_count_macros.svh"

module gtrc_checker import gtrc_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic [COUNT_W-1:0] o_count,
    input wire logic               o_status
);

    // Hold a stalled result beat.
    `GTRC_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_count) && $stable(o_status), "result beat changed while stalled")

    `GTRC_ASSERT(a_bad_zero, o_out_valid && (o_status == STATUS_BAD) |-> (o_count == '0), "bad-coordinate result with nonzero count")

    `GTRC_ASSERT(a_count_max, o_out_valid |-> (o_count <= MAX_COUNT), "count beyond grid area")

    // Reset drops any result and starts the clearing pass.
    `GTRC_ASSERT_ALWAYS(a_rst_quiet, !i_rst_n |=> !o_out_valid && !o_in_ready, "block active right after reset")

endmodule

bind grid_toggle_rectangle_count gtrc_checker u_gtrc_checker (.*);

`default_nettype wire
